// ===== hdl/serial_command_line_matcher_defines.svh =====
// Assertion macros for the command line matcher
`ifndef SERIAL_COMMAND_LINE_MATCHER_DEFINES_SVH
`define SERIAL_COMMAND_LINE_MATCHER_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define SCL_ASSERT_IMPL(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (con)) \
		else $error("command line matcher check failed");

// next-cycle implication, clocked on clk, off during reset
`define SCL_ASSERT_NEXT(lbl, ant, con) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (con)) \
		else $error("command line matcher check failed");

`endif

// ===== hdl/scl_pkg.sv =====
package scl_pkg;

	localparam int BUF_SIZE     = 64;
	localparam int CMD_CHARS    = 8;
	localparam int MAX_COMMANDS = 16;

	localparam int BUF_AW  = $clog2(BUF_SIZE);
	localparam int FILL_W  = $clog2(BUF_SIZE + 1);
	localparam int CHR_W   = $clog2(CMD_CHARS);
	localparam int ENT_W   = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
	localparam int CNT_W   = $clog2(MAX_COMMANDS + 1);
	localparam int TAB_AW  = $clog2(MAX_COMMANDS * CMD_CHARS);
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		REG_NEWLINE = 2'd0,
		REG_DELIM   = 2'd1,
		REG_ECHO    = 2'd2,
		REG_COUNT   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		LS_NONE    = 2'd0,
		LS_MATCH   = 2'd1,
		LS_UNKNOWN = 2'd2
	} line_status_t;

	typedef enum logic {
		RK_ECHO = 1'b0,
		RK_LINE = 1'b1
	} result_kind_t;

	typedef enum logic {
		ACT_CHAR = 1'b0,
		ACT_LOAD = 1'b1
	} action_t;

	typedef struct packed {
		logic [7:0]         delim;
		logic [COUNT_W-1:0] count;
	} seq_cfg_t;

	typedef struct packed {
		logic               valid;
		line_status_t       status;
		logic [ENT_W-1:0]   index;
		logic [BUF_AW-1:0]  start;
		logic [FILL_W-1:0]  length;
	} line_res_t;

endpackage

// ===== hdl/scl_line_buf.sv =====
module scl_line_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [7:0]                  wr_char,
	input  logic                        clr,
	input  logic [scl_pkg::BUF_AW-1:0]  rd_addr,
	output logic [7:0]                  rd_data,
	output logic [scl_pkg::FILL_W-1:0]  fill
);

	logic [7:0]                 mem [scl_pkg::BUF_SIZE];
	logic [7:0]                 rd_data_q;
	logic [scl_pkg::FILL_W-1:0] fill_q;
	logic                       room;

	assign room    = 32'(fill_q) < scl_pkg::BUF_SIZE;
	assign fill    = fill_q;
	assign rd_data = rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (clr) begin
			fill_q <= '0;
		end else if (wr_en && room) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && room) begin
			mem[fill_q[scl_pkg::BUF_AW-1:0]] <= wr_char;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

// ===== hdl/scl_cmd_table.sv =====
module scl_cmd_table (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [3:0]                  wr_entry,
	input  logic [2:0]                  wr_pos,
	input  logic [7:0]                  wr_char,
	input  logic [scl_pkg::TAB_AW-1:0]  rd_addr,
	output logic [7:0]                  rd_data
);

	logic [7:0]                 mem [scl_pkg::MAX_COMMANDS * scl_pkg::CMD_CHARS];
	logic [7:0]                 rd_data_q;
	logic [scl_pkg::TAB_AW-1:0] wr_addr;
	logic                       wr_ok;

	assign wr_ok   = (32'(wr_entry) < scl_pkg::MAX_COMMANDS) &&
			(32'(wr_pos) < scl_pkg::CMD_CHARS);
	assign wr_addr = scl_pkg::TAB_AW'(32'(wr_entry) * scl_pkg::CMD_CHARS + 32'(wr_pos));
	assign rd_data = rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en && wr_ok) begin
			mem[wr_addr] <= wr_char;
		end
		rd_data_q <= mem[rd_addr];
	end

endmodule

// ===== hdl/scl_seq.sv =====
module scl_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  logic [scl_pkg::FILL_W-1:0]  fill,
	input  scl_pkg::seq_cfg_t           cfg,
	output logic [scl_pkg::BUF_AW-1:0]  buf_raddr,
	input  logic [7:0]                  buf_rdata,
	output logic [scl_pkg::TAB_AW-1:0]  tab_raddr,
	input  logic [7:0]                  tab_rdata,
	output logic                        busy,
	output scl_pkg::line_res_t          res
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN_RD  = 6'b000010,
		ST_SCAN_CHK = 6'b000100,
		ST_EVAL     = 6'b001000,
		ST_CMP_RD   = 6'b010000,
		ST_CMP_CHK  = 6'b100000
	} state_t;

	state_t                     state_q;
	logic [scl_pkg::FILL_W-1:0] i_q;
	logic [scl_pkg::FILL_W-1:0] n_q;
	logic [scl_pkg::FILL_W-1:0] len_q;
	logic [scl_pkg::BUF_AW-1:0] start_q;
	logic                       skip_q;
	logic [scl_pkg::ENT_W-1:0]  e_q;
	logic [scl_pkg::CHR_W-1:0]  k_q;
	logic [scl_pkg::CNT_W-1:0]  cnt;
	logic [7:0]                 a_chr;
	logic                       is_delim;
	logic                       mismatch;
	logic                       hit;
	logic                       e_more;

	assign cnt = (32'(cfg.count) > scl_pkg::MAX_COMMANDS) ?
			scl_pkg::CNT_W'(scl_pkg::MAX_COMMANDS) : scl_pkg::CNT_W'(cfg.count);
	assign is_delim = buf_rdata == cfg.delim;
	assign a_chr    = (32'(k_q) < 32'(len_q)) ? buf_rdata : 8'd0;
	assign mismatch = a_chr != tab_rdata;
	assign hit      = (a_chr == 8'd0) || (32'(k_q) == scl_pkg::CMD_CHARS - 1);
	assign e_more   = (32'(e_q) + 1) < 32'(cnt);
	assign busy     = state_q != ST_IDLE;

	assign buf_raddr = (state_q == ST_CMP_RD) ?
			start_q + scl_pkg::BUF_AW'(k_q) : i_q[scl_pkg::BUF_AW-1:0];
	assign tab_raddr = scl_pkg::TAB_AW'(32'(e_q) * scl_pkg::CMD_CHARS + 32'(k_q));

	always_comb begin
		res        = '0;
		res.status = scl_pkg::LS_NONE;
		res.start  = start_q;
		res.length = len_q;
		res.index  = e_q;
		unique case (state_q)
			ST_EVAL: begin
				if (len_q == '0) begin
					res.valid = 1'b1;
					res.start = '0;
					res.index = '0;
				end else if (cnt == '0) begin
					res.valid  = 1'b1;
					res.status = scl_pkg::LS_UNKNOWN;
					res.index  = '0;
				end
			end
			ST_CMP_CHK: begin
				if (mismatch) begin
					res.valid  = !e_more;
					res.status = scl_pkg::LS_UNKNOWN;
					res.index  = '0;
				end else if (hit) begin
					res.valid  = 1'b1;
					res.status = scl_pkg::LS_MATCH;
				end
			end
			default: begin
				res.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) state_q <= ST_SCAN_RD;
				end
				ST_SCAN_RD: begin
					state_q <= (i_q >= n_q) ? ST_EVAL : ST_SCAN_CHK;
				end
				ST_SCAN_CHK: begin
					state_q <= (is_delim && !skip_q) ? ST_EVAL : ST_SCAN_RD;
				end
				ST_EVAL: begin
					state_q <= (len_q == '0 || cnt == '0) ? ST_IDLE : ST_CMP_RD;
				end
				ST_CMP_RD: begin
					state_q <= ST_CMP_CHK;
				end
				ST_CMP_CHK: begin
					if (mismatch) begin
						state_q <= e_more ? ST_CMP_RD : ST_IDLE;
					end else begin
						state_q <= hit ? ST_IDLE : ST_CMP_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				i_q     <= '0;
				n_q     <= fill;
				len_q   <= '0;
				start_q <= '0;
				skip_q  <= 1'b1;
			end
			ST_SCAN_CHK: begin
				if (!is_delim) begin
					if (skip_q) start_q <= i_q[scl_pkg::BUF_AW-1:0];
					skip_q <= 1'b0;
					len_q  <= len_q + 1'b1;
					i_q    <= i_q + 1'b1;
				end else if (skip_q) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_EVAL: begin
				e_q <= '0;
				k_q <= '0;
			end
			ST_CMP_CHK: begin
				if (mismatch) begin
					e_q <= e_q + 1'b1;
					k_q <= '0;
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
			default: begin
				skip_q <= skip_q;
			end
		endcase
	end

endmodule

// ===== hdl/serial_command_line_matcher.sv =====
// Channel   Handshake                  Payload
// request   start in, busy out         action, data_char, table_entry, table_pos
// result    strobe out (one cycle)     result_kind, echo_char, echo_newline,
//                                      line_status, match_index, token_start,
//                                      token_length
// config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// A character or table load is written when accepted; an echo strobes in the cycle after.
// A newline scans the buffer up to the token end, evaluates the token, then
// compares it with each table entry character by character through registered
// reads, the result strobing as busy falls.
// arst_n resets fill count, sequencer state, strobe and config; not the memories.
// The receiver cannot stall: each result shows for one cycle on strobe.
module serial_command_line_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [7:0]  data_char,
	input  logic [3:0]  table_entry,
	input  logic [2:0]  table_pos,
	output logic        strobe,
	output logic        result_kind,
	output logic [7:0]  echo_char,
	output logic        echo_newline,
	output logic [1:0]  line_status,
	output logic [3:0]  match_index,
	output logic [5:0]  token_start,
	output logic [6:0]  token_length,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	`include "serial_command_line_matcher_defines.svh"

	logic [7:0]                  newline_q;
	logic [7:0]                  delim_q;
	logic                        echo_q;
	logic [scl_pkg::COUNT_W-1:0] count_q;

	logic                        accept;
	logic                        is_char;
	logic                        is_newline;
	logic                        printable;
	logic                        seq_busy;
	logic                        cfg_wr;
	logic [scl_pkg::FILL_W-1:0]  fill;
	logic [scl_pkg::BUF_AW-1:0]  buf_raddr;
	logic [7:0]                  buf_rdata;
	logic [scl_pkg::TAB_AW-1:0]  tab_raddr;
	logic [7:0]                  tab_rdata;
	scl_pkg::seq_cfg_t           seq_cfg;
	scl_pkg::line_res_t          res;

	logic        strobe_q;
	logic        kind_q;
	logic [7:0]  echo_char_q;
	logic        echo_nl_q;
	logic [1:0]  status_q;
	logic [3:0]  index_q;
	logic [5:0]  tstart_q;
	logic [6:0]  tlen_q;

	assign busy       = seq_busy;
	assign accept     = start && !seq_busy;
	assign is_char    = action == scl_pkg::ACT_CHAR;
	assign is_newline = is_char && (data_char == newline_q);
	assign printable  = is_char && !is_newline && (data_char >= 8'h20) && (data_char <= 8'h7E);
	assign cfg_wr     = psel && penable && pwrite;
	assign pready     = 1'b1;

	assign seq_cfg.delim = delim_q;
	assign seq_cfg.count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newline_q <= 8'd10;
			delim_q   <= 8'd32;
			echo_q    <= 1'b0;
			count_q   <= '0;
		end else if (cfg_wr) begin
			unique case (scl_pkg::reg_idx_t'(paddr[3:2]))
				scl_pkg::REG_NEWLINE: newline_q <= pwdata[7:0];
				scl_pkg::REG_DELIM:   delim_q   <= pwdata[7:0];
				scl_pkg::REG_ECHO:    echo_q    <= pwdata[0];
				scl_pkg::REG_COUNT:   count_q   <= pwdata[scl_pkg::COUNT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (scl_pkg::reg_idx_t'(paddr[3:2]))
			scl_pkg::REG_NEWLINE: prdata = {24'd0, newline_q};
			scl_pkg::REG_DELIM:   prdata = {24'd0, delim_q};
			scl_pkg::REG_ECHO:    prdata = {31'd0, echo_q};
			scl_pkg::REG_COUNT:   prdata = {{(32 - scl_pkg::COUNT_W){1'b0}}, count_q};
		endcase
	end

	scl_line_buf u_line_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && printable),
		.wr_char (data_char),
		.clr     (accept && is_newline),
		.rd_addr (buf_raddr),
		.rd_data (buf_rdata),
		.fill    (fill)
	);

	scl_cmd_table u_cmd_table (
		.clk      (clk),
		.wr_en    (accept && (action == scl_pkg::ACT_LOAD)),
		.wr_entry (table_entry),
		.wr_pos   (table_pos),
		.wr_char  (data_char),
		.rd_addr  (tab_raddr),
		.rd_data  (tab_rdata)
	);

	scl_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (accept && is_newline),
		.fill      (fill),
		.cfg       (seq_cfg),
		.buf_raddr (buf_raddr),
		.buf_rdata (buf_rdata),
		.tab_raddr (tab_raddr),
		.tab_rdata (tab_rdata),
		.busy      (seq_busy),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= res.valid || (accept && printable && echo_q);
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			kind_q      <= scl_pkg::RK_LINE;
			echo_char_q <= 8'd0;
			echo_nl_q   <= echo_q;
			status_q    <= res.status;
			index_q     <= 4'(res.index);
			tstart_q    <= 6'(res.start);
			tlen_q      <= 7'(res.length);
		end else begin
			kind_q      <= scl_pkg::RK_ECHO;
			echo_char_q <= data_char;
			echo_nl_q   <= 1'b0;
			status_q    <= scl_pkg::LS_NONE;
			index_q     <= 4'd0;
			tstart_q    <= 6'd0;
			tlen_q      <= 7'd0;
		end
	end

	assign strobe       = strobe_q;
	assign result_kind  = kind_q;
	assign echo_char    = echo_char_q;
	assign echo_newline = echo_nl_q;
	assign line_status  = status_q;
	assign match_index  = index_q;
	assign token_start  = tstart_q;
	assign token_length = tlen_q;

	`SCL_ASSERT_IMPL(a_line_after_busy, strobe && (result_kind == scl_pkg::RK_LINE), $past(busy))
	`SCL_ASSERT_NEXT(a_newline_busy, accept && is_newline, busy && !strobe)
	`SCL_ASSERT_IMPL(a_match_has_token, strobe && (line_status == scl_pkg::LS_MATCH), token_length != 7'd0)

endmodule
